[rtl/arm_preset_position_pid_top_defines.svh]
// Assertion macros shared by the arm position controller RTL.
`ifndef ARM_PRESET_POSITION_PID_TOP_DEFINES_SVH
`define ARM_PRESET_POSITION_PID_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define APPID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked during reset as well
`define APPID_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define APPID_ASSERT(lbl, prop, msg)
`define APPID_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[rtl/appid_pkg.sv]
// Types, constants and helpers for the arm preset position controller.
package appid_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int POSITION_BITS_DEF  = 24;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 18;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN    = 4'd0,
    REG_INTEG_GAIN   = 4'd1,
    REG_DERIV_GAIN   = 4'd2,
    REG_INTEG_LIMIT  = 4'd3,
    REG_MAX_ANGLE    = 4'd4,
    REG_SCORE_CUTOFF = 4'd5,
    REG_JOG_STEP     = 4'd6,
    REG_DRIVE_LIMIT  = 4'd7
  } cfg_reg_e;

  localparam logic [17:0] PROP_GAIN_RST    = 18'd78643;
  localparam logic [15:0] INTEG_GAIN_RST   = 16'd3932;
  localparam logic [17:0] DERIV_GAIN_RST   = 18'd39322;
  localparam logic [12:0] INTEG_LIMIT_RST  = 13'd5000;
  localparam logic [15:0] MAX_ANGLE_RST    = 16'd25000;
  localparam logic [15:0] SCORE_CUTOFF_RST = 16'd13000;
  localparam logic [9:0]  JOG_STEP_RST     = 10'd200;
  localparam logic [13:0] DRIVE_LIMIT_RST  = 14'd12000;

  localparam logic signed [16:0] REST_ANGLE  = 17'sd300;
  localparam logic signed [16:0] SCORE_ANGLE = 17'sd14000;

  typedef enum logic [1:0] {
    PRESET_REST     = 2'd0,
    PRESET_GRAB     = 2'd1,
    PRESET_PRESCORE = 2'd2,
    PRESET_SCORE    = 2'd3
  } preset_e;

  // Per-tick control info that rides along with the PID operands.
  typedef struct packed {
    logic signed [16:0] target;
    logic [1:0]         preset;
    logic               score;     // bang-bang drive selected
    logic               score_on;  // angle below score cutoff
  } tick_info_t;

  function automatic logic signed [16:0] preset_angle(input logic [1:0] idx);
    logic signed [16:0] a;
    case (idx)
      PRESET_REST:     a = 17'sd300;
      PRESET_GRAB:     a = 17'sd3500;
      PRESET_PRESCORE: a = 17'sd8000;
      PRESET_SCORE:    a = 17'sd14000;
      default:         a = 17'sd300;
    endcase
    return a;
  endfunction

  function automatic logic [1:0] preset_step(input logic [1:0] idx);
    logic [1:0] n;
    case (idx)
      PRESET_REST:     n = PRESET_GRAB;
      PRESET_GRAB:     n = PRESET_PRESCORE;
      PRESET_PRESCORE: n = PRESET_SCORE;
      PRESET_SCORE:    n = PRESET_GRAB;
      default:         n = PRESET_GRAB;
    endcase
    return n;
  endfunction

endpackage

[rtl/appid_ctrl.sv]
// Target/preset update, PID state and first pipeline register.
module appid_ctrl
  import appid_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int EW = ((POSITION_BITS > 17) ? POSITION_BITS : 17) + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic                       en1,
  input  logic signed [POSITION_BITS-1:0] arm_position,
  input  logic                       manual_btn,
  input  logic                       toggle_btn,
  input  logic                       store_btn,
  input  logic                       set_target_valid,
  input  logic signed [16:0]         set_target_value,
  input  logic [12:0]                integ_limit,
  input  logic [15:0]                max_angle,
  input  logic [15:0]                score_cutoff,
  input  logic [9:0]                 jog_step,
  output tick_info_t                 s1_info,
  output logic signed [EW-1:0]       s1_err,
  output logic signed [13:0]         s1_sum,
  output logic signed [EW:0]         s1_delta
);

  logic signed [16:0] target_angle_reg, target_next;
  logic [1:0]         preset_index, preset_next;
  logic               prev_toggle, prev_toggle_next;
  logic signed [13:0] error_sum, error_sum_next;
  logic signed [EW-1:0] last_error;

  logic signed [17:0] jog_up, jog_dn;
  logic signed [EW-1:0] pos_x, err;
  logic signed [EW:0]   sum_raw, il_x, delta;
  logic               score, score_on;

  always_comb begin
    jog_up           = 18'(target_angle_reg) + $signed({2'b00, jog_step});
    jog_dn           = 18'(target_angle_reg) - $signed({2'b00, jog_step});
    target_next      = target_angle_reg;
    preset_next      = preset_index;
    prev_toggle_next = prev_toggle;
    if (manual_btn) begin
      preset_next = PRESET_REST;
      if (toggle_btn) begin
        if (jog_up > $signed({2'b00, max_angle})) begin
          target_next = 17'($signed({1'b0, max_angle}));
        end else begin
          target_next = 17'(jog_up);
        end
      end else if (store_btn) begin
        if (jog_dn < 18'(REST_ANGLE)) begin
          target_next = REST_ANGLE;
        end else begin
          target_next = 17'(jog_dn);
        end
      end
    end else begin
      if (toggle_btn && !prev_toggle) begin
        preset_next = preset_step(preset_index);
        target_next = preset_angle(preset_next);
      end
      prev_toggle_next = toggle_btn;
      if (store_btn) begin
        preset_next = PRESET_REST;
        target_next = REST_ANGLE;
      end
    end
    if (set_target_valid) begin
      target_next = set_target_value;
    end
  end

  always_comb begin
    pos_x    = EW'(arm_position);
    score    = (target_next == SCORE_ANGLE);
    score_on = (pos_x < EW'($signed({1'b0, score_cutoff})));
    err      = EW'(target_next) - pos_x;
    delta    = (EW+1)'(err) - (EW+1)'(last_error);
    sum_raw  = (EW+1)'(error_sum) + (EW+1)'(err);
    il_x     = (EW+1)'($signed({1'b0, integ_limit}));
    if (sum_raw > il_x) begin
      error_sum_next = 14'(il_x);
    end else if (sum_raw < -il_x) begin
      error_sum_next = 14'(-il_x);
    end else begin
      error_sum_next = 14'(sum_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle_reg <= REST_ANGLE;
      preset_index     <= PRESET_REST;
      prev_toggle      <= 1'b0;
      error_sum        <= '0;
      last_error       <= '0;
    end else if (take) begin
      target_angle_reg <= target_next;
      preset_index     <= preset_next;
      prev_toggle      <= prev_toggle_next;
      // PID state holds while the bang-bang drive is in use
      if (!score) begin
        error_sum  <= error_sum_next;
        last_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_info.target   <= target_next;
      s1_info.preset   <= preset_next;
      s1_info.score    <= score;
      s1_info.score_on <= score_on;
      s1_err           <= err;
      s1_sum           <= error_sum_next;
      s1_delta         <= delta;
    end
  end

endmodule

[rtl/appid_mac.sv]
// PID gain multiply, sum, floor shift and drive saturation (two stages).
module appid_mac
  import appid_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int POSITION_BITS  = POSITION_BITS_DEF,
  parameter int EW = ((POSITION_BITS > 17) ? POSITION_BITS : 17) + 1
) (
  input  logic                 clk,
  input  logic                 en2,
  input  logic                 en_out,
  input  logic [17:0]          prop_gain,
  input  logic [15:0]          integ_gain,
  input  logic [17:0]          deriv_gain,
  input  logic [13:0]          drive_limit,
  input  tick_info_t           s1_info,
  input  logic signed [EW-1:0] s1_err,
  input  logic signed [13:0]   s1_sum,
  input  logic signed [EW:0]   s1_delta,
  output tick_info_t           out_info,
  output logic signed [14:0]   out_drive
);

  localparam int PW = EW + 19;
  localparam int IW = 31;
  localparam int DW = EW + 20;
  localparam int AW = DW + 2;

  tick_info_t s2_info;
  logic signed [PW-1:0] prod_p;
  logic signed [IW-1:0] prod_i;
  logic signed [DW-1:0] prod_d;
  logic signed [AW-1:0] acc, shifted, lim_x;
  logic signed [14:0]   drive_next;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_info <= s1_info;
      prod_p  <= $signed({1'b0, prop_gain}) * s1_err;
      prod_i  <= $signed({1'b0, integ_gain}) * s1_sum;
      prod_d  <= $signed({1'b0, deriv_gain}) * s1_delta;
    end
  end

  always_comb begin
    acc     = AW'(prod_p) + AW'(prod_i) + AW'(prod_d);
    shifted = acc >>> GAIN_FRAC_BITS;  // arithmetic shift floors
    lim_x   = AW'($signed({1'b0, drive_limit}));
    if (s2_info.score) begin
      drive_next = s2_info.score_on ? $signed({1'b0, drive_limit}) : '0;
    end else if (shifted > lim_x) begin
      drive_next = $signed({1'b0, drive_limit});
    end else if (shifted < -lim_x) begin
      drive_next = -$signed({1'b0, drive_limit});
    end else begin
      drive_next = 15'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_info  <= s2_info;
      out_drive <= drive_next;
    end
  end

endmodule

[rtl/arm_preset_position_pid_top.sv]
// Top level of the arm preset position controller with clamped-integral PID.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | one control tick: position and buttons
//  m_*     | out | m_tvalid/m_tready  | drive, target, preset, score flag
//  cfg_*   | in  | cfg_valid/cfg_ready| register index and write data
//
// One tick per cycle sustained over three register stages while the output is not stalled;
// the valid bit of an accepted tick passes through s1_valid and s2_valid into m_tvalid.
// Target, preset and PID state update in the accept cycle itself, so ticks may follow
// back to back; gains multiply in stage 2, sum and saturation in stage 3. Synchronous
// reset loads the rest target and register defaults. A stalled output holds each stage
// in turn; input stalls only when all are full.
`include "arm_preset_position_pid_top_defines.svh"

module arm_preset_position_pid_top
  import appid_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int POSITION_BITS  = POSITION_BITS_DEF,
  localparam int IN_BITS  = POSITION_BITS + 21,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 34,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
  localparam int EW = ((POSITION_BITS > 17) ? POSITION_BITS : 17) + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // arm_position, manual_btn, toggle_btn, store_btn, set_target_valid,
  // set_target_value, zero fill
  input  logic [IN_W-1:0]        s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // drive_mv[14:0], target_angle[31:15], preset_now[33:32], zero fill
  output logic [OUT_W-1:0]       m_tdata,
  // score_active
  output logic                   m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [17:0] prop_gain;
  logic [15:0] integ_gain;
  logic [17:0] deriv_gain;
  logic [12:0] integ_limit;
  logic [15:0] max_angle;
  logic [15:0] score_cutoff;
  logic [9:0]  jog_step;
  logic [13:0] drive_limit;

  logic s1_valid, s2_valid;
  logic en1, en2, en_out, take;

  tick_info_t            s1_info, out_info;
  logic signed [EW-1:0]  s1_err;
  logic signed [13:0]    s1_sum;
  logic signed [EW:0]    s1_delta;
  logic signed [14:0]    out_drive;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= PROP_GAIN_RST;
      integ_gain   <= INTEG_GAIN_RST;
      deriv_gain   <= DERIV_GAIN_RST;
      integ_limit  <= INTEG_LIMIT_RST;
      max_angle    <= MAX_ANGLE_RST;
      score_cutoff <= SCORE_CUTOFF_RST;
      jog_step     <= JOG_STEP_RST;
      drive_limit  <= DRIVE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:    prop_gain    <= cfg_data[17:0];
        REG_INTEG_GAIN:   integ_gain   <= cfg_data[15:0];
        REG_DERIV_GAIN:   deriv_gain   <= cfg_data[17:0];
        REG_INTEG_LIMIT:  integ_limit  <= cfg_data[12:0];
        REG_MAX_ANGLE:    max_angle    <= cfg_data[15:0];
        REG_SCORE_CUTOFF: score_cutoff <= cfg_data[15:0];
        REG_JOG_STEP:     jog_step     <= cfg_data[9:0];
        REG_DRIVE_LIMIT:  drive_limit  <= cfg_data[13:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // each stage moves when the one after it is empty or moving
  assign en_out   = !m_tvalid || m_tready;
  assign en2      = !s2_valid || en_out;
  assign en1      = !s1_valid || en2;
  assign s_tready = en1;
  assign take     = s_tvalid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1)    s1_valid <= take;
      if (en2)    s2_valid <= s1_valid;
      if (en_out) m_tvalid <= s2_valid;
    end
  end

  appid_ctrl #(
    .POSITION_BITS(POSITION_BITS),
    .EW(EW)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .en1              (en1),
    .arm_position     ($signed(s_tdata[POSITION_BITS-1:0])),
    .manual_btn       (s_tdata[POSITION_BITS]),
    .toggle_btn       (s_tdata[POSITION_BITS+1]),
    .store_btn        (s_tdata[POSITION_BITS+2]),
    .set_target_valid (s_tdata[POSITION_BITS+3]),
    .set_target_value ($signed(s_tdata[POSITION_BITS+20:POSITION_BITS+4])),
    .integ_limit      (integ_limit),
    .max_angle        (max_angle),
    .score_cutoff     (score_cutoff),
    .jog_step         (jog_step),
    .s1_info          (s1_info),
    .s1_err           (s1_err),
    .s1_sum           (s1_sum),
    .s1_delta         (s1_delta)
  );

  appid_mac #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .POSITION_BITS (POSITION_BITS),
    .EW            (EW)
  ) u_mac (
    .clk         (clk),
    .en2         (en2),
    .en_out      (en_out),
    .prop_gain   (prop_gain),
    .integ_gain  (integ_gain),
    .deriv_gain  (deriv_gain),
    .drive_limit (drive_limit),
    .s1_info     (s1_info),
    .s1_err      (s1_err),
    .s1_sum      (s1_sum),
    .s1_delta    (s1_delta),
    .out_info    (out_info),
    .out_drive   (out_drive)
  );

  assign m_tdata = {(OUT_W - OUT_BITS)'(0), out_info.preset, out_info.target, out_drive};
  assign m_tuser = out_info.score;

  `APPID_ASSERT(a_drive_in_limit,
    m_tvalid |-> ((out_drive <= $signed({1'b0, drive_limit})) &&
                  (out_drive >= -$signed({1'b0, drive_limit}))),
    "drive beyond saturation limit")
  `APPID_ASSERT(a_score_target,
    (m_tvalid && m_tuser) |-> (out_info.target == SCORE_ANGLE),
    "score drive without score target")
  `APPID_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with output empty")
  `APPID_ASSERT_RST(a_reset_clears,
    rst |=> (!m_tvalid && !s1_valid && !s2_valid),
    "pipeline valid after reset")

endmodule
